### sv/assert_macros.svh
// Assertion helpers for the window bounds core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GWB_ASSERT(lbl, prop, msg)
`define GWB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/gwb_pkg.sv
`default_nettype none

package gwb_pkg;

  localparam int LAT_W       = 16;
  localparam int LON_W       = 17;
  localparam int LON_START_W = 12;
  localparam int LON_EXT_W   = 13;
  localparam int LAT_START_W = 11;
  localparam int LAT_EXT_W   = 12;

  localparam int LON_CELLS      = 3600;
  localparam int LAT_CELLS      = 1800;
  localparam int CELLS_PER_DEG  = 10;
  localparam int LON_BASE_DEG   = 180;
  localparam int LAT_BASE_DEG   = 90;
  localparam int WRAP_LIMIT_DEG = 175;
  localparam int PAD_LO_DEG     = 1;
  localparam int PAD_HI_DEG     = 2;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat_deg;
    logic signed [LON_W-1:0] lon_deg;
    logic                    sample_valid;
    logic                    last_sample;
  } gwb_item_t;

endpackage

`default_nettype wire

### sv/geo_window_bounds_core.sv
// Geolocation window bounds core.
// Input channel (in_*): one latitude/longitude sample per item, degrees in
// signed fixed point with FRAC_BITS fraction bits. Samples with
// in_sample_valid low are fill and do not move the extents. The item with
// in_last_sample high closes the granule.
// Result channel (out_*): one item per closing sample, giving the start and
// extent of the tenth-degree window on the 3600 x 1800 grid, the wrap offset
// and the dateline flag. Extents restart right after the closing sample.
// A closing sample passes the input register, the snapshot register and the
// output register in that order before it is shown on out_valid.
// Throughput: one item per cycle while in_stall is low. Two finished results can wait (snapshot
// and output register), so a stalled receiver only holds off the input once
// a further closing sample arrives with both slots full; ordinary samples
// keep flowing while a result waits.
// Reset (rst_n low at a clock edge): pipeline empties, extents return to
// +/-90 and +/-180 degrees, no result pending.
`default_nettype none
`include "assert_macros.svh"

module geo_window_bounds_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [gwb_pkg::LAT_W-1:0]        in_lat_deg,
  input  logic signed [gwb_pkg::LON_W-1:0]        in_lon_deg,
  input  logic                                    in_sample_valid,
  input  logic                                    in_last_sample,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [gwb_pkg::LON_START_W-1:0]         out_lon_start,
  output logic signed [gwb_pkg::LON_EXT_W-1:0]    out_lon_extent,
  output logic [gwb_pkg::LAT_START_W-1:0]         out_lat_start,
  output logic signed [gwb_pkg::LAT_EXT_W-1:0]    out_lat_extent,
  output logic [gwb_pkg::LON_START_W-1:0]         out_wrap_offset,
  output logic                                    out_crosses_dateline
);
  import gwb_pkg::*;

  localparam int TRK_W = (FRAC_BITS + 9 > LON_W) ? FRAC_BITS + 9 : LON_W;

  logic      a_valid_r, a_valid_nxt;
  gwb_item_t a_item_r, a_item_nxt;
  logic      in_take;
  logic      a_go;
  logic      snap_valid;
  logic      snap_take;
  logic      snap_free;

  logic signed [TRK_W-1:0] snap_min_lat;
  logic signed [TRK_W-1:0] snap_max_lat;
  logic signed [TRK_W-1:0] snap_min_lon;
  logic signed [TRK_W-1:0] snap_max_lon;
  logic signed [TRK_W-1:0] snap_east;
  logic signed [TRK_W-1:0] snap_west;

  assign snap_free = !snap_valid || snap_take;
  assign a_go      = a_valid_r && (!a_item_r.last_sample || snap_free);
  assign in_stall  = a_valid_r && !a_go;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    a_item_nxt = '{lat_deg: in_lat_deg, lon_deg: in_lon_deg,
                   sample_valid: in_sample_valid, last_sample: in_last_sample};
    a_valid_nxt = a_valid_r;
    if (in_take) begin
      a_valid_nxt = 1'b1;
    end else if (a_go) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_item_r <= a_item_nxt;
    end
  end

  gwb_track #(
    .FRAC_BITS (FRAC_BITS),
    .TRK_W     (TRK_W)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (a_item_r),
    .item_go      (a_go),
    .snap_take    (snap_take),
    .snap_valid   (snap_valid),
    .snap_min_lat (snap_min_lat),
    .snap_max_lat (snap_max_lat),
    .snap_min_lon (snap_min_lon),
    .snap_max_lon (snap_max_lon),
    .snap_east    (snap_east),
    .snap_west    (snap_west)
  );

  gwb_window #(
    .FRAC_BITS (FRAC_BITS),
    .TRK_W     (TRK_W)
  ) u_window (
    .clk                  (clk),
    .rst_n                (rst_n),
    .snap_valid           (snap_valid),
    .snap_take            (snap_take),
    .snap_min_lat         (snap_min_lat),
    .snap_max_lat         (snap_max_lat),
    .snap_min_lon         (snap_min_lon),
    .snap_max_lon         (snap_max_lon),
    .snap_east            (snap_east),
    .snap_west            (snap_west),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_lon_start        (out_lon_start),
    .out_lon_extent       (out_lon_extent),
    .out_lat_start        (out_lat_start),
    .out_lat_extent       (out_lat_extent),
    .out_wrap_offset      (out_wrap_offset),
    .out_crosses_dateline (out_crosses_dateline)
  );

  `GWB_ASSERT(a_plain_flows, (in_valid && !in_stall && !in_last_sample) |=> !in_stall, "stall after an ordinary item")
  `GWB_ASSERT(a_result_src, $rose(out_valid) |-> $past(a_valid_r && a_item_r.last_sample, 2), "result without a closing item")
  `GWB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid && !in_stall), "pipeline not empty after reset")

endmodule

`default_nettype wire

### sv/gwb_track.sv
`default_nettype none
`include "assert_macros.svh"

module gwb_track #(
  parameter int FRAC_BITS = 8,
  parameter int TRK_W     = 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gwb_pkg::gwb_item_t      item,
  input  logic                    item_go,
  input  logic                    snap_take,
  output logic                    snap_valid,
  output logic signed [TRK_W-1:0] snap_min_lat,
  output logic signed [TRK_W-1:0] snap_max_lat,
  output logic signed [TRK_W-1:0] snap_min_lon,
  output logic signed [TRK_W-1:0] snap_max_lon,
  output logic signed [TRK_W-1:0] snap_east,
  output logic signed [TRK_W-1:0] snap_west
);
  import gwb_pkg::*;

  localparam logic signed [TRK_W-1:0] LAT_HI = TRK_W'(LAT_BASE_DEG * (2 ** FRAC_BITS));
  localparam logic signed [TRK_W-1:0] LAT_LO = TRK_W'(-LAT_BASE_DEG * (2 ** FRAC_BITS));
  localparam logic signed [TRK_W-1:0] LON_HI = TRK_W'(LON_BASE_DEG * (2 ** FRAC_BITS));
  localparam logic signed [TRK_W-1:0] LON_LO = TRK_W'(-LON_BASE_DEG * (2 ** FRAC_BITS));

  logic signed [TRK_W-1:0] lat;
  logic signed [TRK_W-1:0] lon;
  logic                    lon_pos;
  logic                    lon_neg;

  logic signed [TRK_W-1:0] min_lat_r, min_lat_nxt;
  logic signed [TRK_W-1:0] max_lat_r, max_lat_nxt;
  logic signed [TRK_W-1:0] min_lon_r, min_lon_nxt;
  logic signed [TRK_W-1:0] max_lon_r, max_lon_nxt;
  logic signed [TRK_W-1:0] east_r, east_nxt;
  logic signed [TRK_W-1:0] west_r, west_nxt;

  logic                    snap_valid_r, snap_valid_nxt;
  logic                    snap_load;
  logic signed [TRK_W-1:0] snap_min_lat_r;
  logic signed [TRK_W-1:0] snap_max_lat_r;
  logic signed [TRK_W-1:0] snap_min_lon_r;
  logic signed [TRK_W-1:0] snap_max_lon_r;
  logic signed [TRK_W-1:0] snap_east_r;
  logic signed [TRK_W-1:0] snap_west_r;

  assign lat     = TRK_W'(item.lat_deg);
  assign lon     = TRK_W'(item.lon_deg);
  assign lon_neg = lon[TRK_W-1];
  assign lon_pos = !lon[TRK_W-1] && (lon != '0);

  always_comb begin
    min_lat_nxt = min_lat_r;
    max_lat_nxt = max_lat_r;
    min_lon_nxt = min_lon_r;
    max_lon_nxt = max_lon_r;
    east_nxt    = east_r;
    west_nxt    = west_r;
    if (item.sample_valid) begin
      if (lat < min_lat_r) min_lat_nxt = lat;
      if (lat > max_lat_r) max_lat_nxt = lat;
      if (lon < min_lon_r) min_lon_nxt = lon;
      if (lon > max_lon_r) max_lon_nxt = lon;
      if (lon_pos && (lon < east_r)) east_nxt = lon;
      if (lon_neg && (lon > west_r)) west_nxt = lon;
    end
  end

  assign snap_load = item_go && item.last_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_lat_r <= LAT_HI;
      max_lat_r <= LAT_LO;
      min_lon_r <= LON_HI;
      max_lon_r <= LON_LO;
      east_r    <= LON_HI;
      west_r    <= LON_LO;
    end else if (snap_load) begin
      min_lat_r <= LAT_HI;
      max_lat_r <= LAT_LO;
      min_lon_r <= LON_HI;
      max_lon_r <= LON_LO;
      east_r    <= LON_HI;
      west_r    <= LON_LO;
    end else if (item_go) begin
      min_lat_r <= min_lat_nxt;
      max_lat_r <= max_lat_nxt;
      min_lon_r <= min_lon_nxt;
      max_lon_r <= max_lon_nxt;
      east_r    <= east_nxt;
      west_r    <= west_nxt;
    end
  end

  always_comb begin
    snap_valid_nxt = snap_valid_r;
    if (snap_load) begin
      snap_valid_nxt = 1'b1;
    end else if (snap_take) begin
      snap_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_min_lat_r <= min_lat_nxt;
      snap_max_lat_r <= max_lat_nxt;
      snap_min_lon_r <= min_lon_nxt;
      snap_max_lon_r <= max_lon_nxt;
      snap_east_r    <= east_nxt;
      snap_west_r    <= west_nxt;
    end
  end

  assign snap_valid   = snap_valid_r;
  assign snap_min_lat = snap_min_lat_r;
  assign snap_max_lat = snap_max_lat_r;
  assign snap_min_lon = snap_min_lon_r;
  assign snap_max_lon = snap_max_lon_r;
  assign snap_east    = snap_east_r;
  assign snap_west    = snap_west_r;

  `GWB_ASSERT(a_trk_restart, snap_load |=> (min_lat_r == LAT_HI && max_lon_r == LON_LO && east_r == LON_HI), "trackers not restarted after last item")
  `GWB_ASSERT(a_snap_hold, (snap_valid_r && !snap_take) |=> ($stable(snap_min_lon_r) && $stable(snap_max_lat_r)), "waiting snapshot changed")
  `GWB_ASSERT(a_trk_idle, !item_go |=> ($stable(min_lon_r) && $stable(west_r)), "trackers moved without an item")

endmodule

`default_nettype wire

### sv/gwb_window.sv
`default_nettype none
`include "assert_macros.svh"

module gwb_window #(
  parameter int FRAC_BITS = 8,
  parameter int TRK_W     = 17
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    snap_valid,
  output logic                                    snap_take,
  input  logic signed [TRK_W-1:0]                 snap_min_lat,
  input  logic signed [TRK_W-1:0]                 snap_max_lat,
  input  logic signed [TRK_W-1:0]                 snap_min_lon,
  input  logic signed [TRK_W-1:0]                 snap_max_lon,
  input  logic signed [TRK_W-1:0]                 snap_east,
  input  logic signed [TRK_W-1:0]                 snap_west,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [gwb_pkg::LON_START_W-1:0]         out_lon_start,
  output logic signed [gwb_pkg::LON_EXT_W-1:0]    out_lon_extent,
  output logic [gwb_pkg::LAT_START_W-1:0]         out_lat_start,
  output logic signed [gwb_pkg::LAT_EXT_W-1:0]    out_lat_extent,
  output logic [gwb_pkg::LON_START_W-1:0]         out_wrap_offset,
  output logic                                    out_crosses_dateline
);
  import gwb_pkg::*;

  localparam int FL_W = TRK_W - FRAC_BITS;
  localparam int CW   = FL_W + 6;

  localparam logic signed [CW-1:0] C_TEN      = CW'(CELLS_PER_DEG);
  localparam logic signed [CW-1:0] C_LON      = CW'(LON_CELLS);
  localparam logic signed [CW-1:0] C_LON_NEG  = CW'(-LON_CELLS);
  localparam logic signed [CW-1:0] C_LON_TOP  = CW'(LON_CELLS + PAD_HI_DEG * CELLS_PER_DEG);
  localparam logic signed [CW-1:0] C_LAT      = CW'(LAT_CELLS);
  localparam logic signed [CW-1:0] C_LAT_NEG  = CW'(-LAT_CELLS);
  localparam logic signed [CW-1:0] C_LAT_TOP  = CW'(LAT_CELLS + PAD_HI_DEG * CELLS_PER_DEG);
  localparam logic signed [CW-1:0] LON_LO_OFS = CW'(LON_BASE_DEG - PAD_LO_DEG);
  localparam logic signed [CW-1:0] LON_HI_OFS = CW'(LON_BASE_DEG + PAD_HI_DEG);
  localparam logic signed [CW-1:0] LAT_LO_OFS = CW'(LAT_BASE_DEG - PAD_LO_DEG);
  localparam logic signed [CW-1:0] LAT_HI_OFS = CW'(LAT_BASE_DEG + PAD_HI_DEG);

  localparam logic signed [TRK_W-1:0] WRAP_POS = TRK_W'(WRAP_LIMIT_DEG * (2 ** FRAC_BITS));
  localparam logic signed [TRK_W-1:0] WRAP_NEG = TRK_W'(-WRAP_LIMIT_DEG * (2 ** FRAC_BITS));

  function automatic logic signed [CW-1:0] floor_deg(input logic signed [TRK_W-1:0] v);
    logic signed [TRK_W-1:0] sh;
    sh = v >>> FRAC_BITS;
    return CW'(sh);
  endfunction

  function automatic logic signed [CW-1:0] to_cells(input logic signed [CW-1:0] fl,
                                                    input logic signed [CW-1:0] ofs);
    return (fl + ofs) * C_TEN;
  endfunction

  function automatic logic signed [CW-1:0] clamp_c(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] lo,
                                                   input logic signed [CW-1:0] hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  logic                 crossing;
  logic signed [CW-1:0] ls_plain, ls_wrap, ls, wrap;
  logic signed [CW-1:0] hi_lon, le_plain, le_wrap, le;
  logic signed [CW-1:0] as_c, hi_lat, ae;
  logic                 out_go;

  logic                              out_valid_r, out_valid_nxt;
  logic [LON_START_W-1:0]            lon_start_r;
  logic signed [LON_EXT_W-1:0]       lon_extent_r;
  logic [LAT_START_W-1:0]            lat_start_r;
  logic signed [LAT_EXT_W-1:0]       lat_extent_r;
  logic [LON_START_W-1:0]            wrap_offset_r;
  logic                              cross_r;

  always_comb begin
    crossing = (snap_min_lon < WRAP_NEG) && (snap_max_lon > WRAP_POS);
    ls_plain = clamp_c(to_cells(floor_deg(snap_min_lon), LON_LO_OFS), '0, C_LON);
    ls_wrap  = clamp_c(to_cells(floor_deg(snap_east), LON_LO_OFS), '0, C_LON);
    ls       = crossing ? ls_wrap : ls_plain;
    wrap     = crossing ? (C_LON - ls_wrap) : '0;
    hi_lon   = to_cells(floor_deg(snap_max_lon), LON_HI_OFS);
    le_plain = ((hi_lon > C_LON) ? C_LON : hi_lon) - ls_plain;
    le_wrap  = to_cells(floor_deg(snap_west), LON_HI_OFS) + wrap;
    le       = clamp_c(crossing ? le_wrap : le_plain, C_LON_NEG, C_LON_TOP);
    as_c     = clamp_c(to_cells(floor_deg(snap_min_lat), LAT_LO_OFS), '0, C_LAT);
    hi_lat   = to_cells(floor_deg(snap_max_lat), LAT_HI_OFS);
    ae       = clamp_c(((hi_lat > C_LAT) ? C_LAT : hi_lat) - as_c, C_LAT_NEG, C_LAT_TOP);
  end

  assign out_go        = !out_valid_r || !out_stall;
  assign snap_take     = snap_valid && out_go;
  assign out_valid_nxt = out_go ? snap_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      lon_start_r   <= ls[LON_START_W-1:0];
      lon_extent_r  <= le[LON_EXT_W-1:0];
      lat_start_r   <= as_c[LAT_START_W-1:0];
      lat_extent_r  <= ae[LAT_EXT_W-1:0];
      wrap_offset_r <= wrap[LON_START_W-1:0];
      cross_r       <= crossing;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_lon_start        = lon_start_r;
  assign out_lon_extent       = lon_extent_r;
  assign out_lat_start        = lat_start_r;
  assign out_lat_extent       = lat_extent_r;
  assign out_wrap_offset      = wrap_offset_r;
  assign out_crosses_dateline = cross_r;

  `GWB_ASSERT(a_wrap_zero, (out_valid && !out_crosses_dateline) |-> (out_wrap_offset == '0), "wrap offset set without dateline crossing")
  `GWB_ASSERT(a_wrap_sum, (out_valid && out_crosses_dateline) |-> ((out_lon_start + out_wrap_offset) == LON_CELLS), "wrap offset does not reach grid end")
  `GWB_ASSERT(a_take_shows, snap_take |=> out_valid, "moved snapshot not presented")

endmodule

`default_nettype wire
